// File: rtl/protobuf_field_encoder_unit_assert.svh
// Assertion macros used by the protobuf field encoder back end.
`ifndef PROTOBUF_FIELD_ENCODER_UNIT_ASSERT_SVH
`define PROTOBUF_FIELD_ENCODER_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PBFE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define PBFE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/pbfe_pkg.sv
// Shared type, constants and helper function of the protobuf field encoder.
`default_nettype none

package pbfe_pkg;

   localparam int MAX_VARINT_BYTES   = 10;
   localparam int VARINT_GROUP_BITS  = 7;
   localparam int VARINT_PAD_WIDTH   = VARINT_GROUP_BITS * MAX_VARINT_BYTES;
   localparam int LIMIT_WIDTH        = 16;
   localparam int KIND_WIDTH         = 3;
   localparam int FIELD_NUM_WIDTH    = 29;
   localparam int VALUE_WIDTH        = 64;
   localparam int TAG_WIDTH          = FIELD_NUM_WIDTH + 3;
   localparam int REQ_DATA_WIDTH     = 96;
   localparam int BYTE_WIDTH         = 8;
   localparam int QUEUE_DEPTH        = 4;
   localparam int QUEUE_PTR_WIDTH    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH  = QUEUE_PTR_WIDTH + 1;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'hFFFF;

   localparam logic [KIND_WIDTH-1:0] KIND_UVARINT = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_ZIGZAG  = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_FIXED32 = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_FIXED64 = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_LENGTH  = 3'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_RAW     = 3'd5;
   localparam logic [KIND_WIDTH-1:0] KIND_RESTART = 3'd6;

   localparam logic [2:0] WIRE_VARINT = 3'd0;
   localparam logic [2:0] WIRE_I64    = 3'd1;
   localparam logic [2:0] WIRE_LEN    = 3'd2;
   localparam logic [2:0] WIRE_I32    = 3'd5;

   typedef struct packed {
      logic                   err;
      logic [TAG_WIDTH-1:0]   tag;
      logic [2:0]             tag_len;
      logic [VALUE_WIDTH-1:0] body;
      logic [3:0]             body_len;
      logic                   body_varint;
   } desc_type;

   // Number of 7-bit groups a varint of this value needs, at least one.
   function automatic logic [3:0] varint_len(input logic [VALUE_WIDTH-1:0] v);
      logic [VARINT_PAD_WIDTH-1:0] w;
      logic [3:0]                  n;
      w = VARINT_PAD_WIDTH'(v);
      n = 4'd1;
      for (int i = 1; i < MAX_VARINT_BYTES; i++) begin
         if (|w[VARINT_GROUP_BITS*i +: VARINT_GROUP_BITS]) begin
            n = 4'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// File: rtl/pbfe_front.sv
// Front end: accepts items, sizes the encoding, checks the buffer budget and queues work.
`default_nettype none

module pbfe_front #(
   parameter int COUNT_BITS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [pbfe_pkg::KIND_WIDTH-1:0]       req_tuser,
   input  wire  [pbfe_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   input  wire                                   csr_wr_en,
   input  wire  [pbfe_pkg::LIMIT_WIDTH-1:0]      csr_wr_data,
   output logic                                  q_push,
   output pbfe_pkg::desc_type                    q_desc,
   input  wire                                   q_full
);

   localparam int CMP_WIDTH =
      ((COUNT_BITS > pbfe_pkg::LIMIT_WIDTH) ? COUNT_BITS : pbfe_pkg::LIMIT_WIDTH) + 1;

   logic [pbfe_pkg::LIMIT_WIDTH-1:0]       limit_ff;
   logic [COUNT_BITS-1:0]                  count_ff, count_in;
   logic                                   sticky_ff, sticky_in;

   logic [pbfe_pkg::KIND_WIDTH-1:0]        kind;
   logic [pbfe_pkg::FIELD_NUM_WIDTH-1:0]   fnum;
   logic [pbfe_pkg::VALUE_WIDTH-1:0]       val;
   logic [pbfe_pkg::VALUE_WIDTH-1:0]       zigzag;
   logic                                   accept;
   logic                                   is_field;
   logic                                   is_raw;
   logic [2:0]                             wire_type;
   logic [pbfe_pkg::VALUE_WIDTH-1:0]       body;
   logic                                   body_varint;
   logic [3:0]                             fixed_len;
   logic [3:0]                             body_len;
   logic [pbfe_pkg::TAG_WIDTH-1:0]         tag;
   logic [2:0]                             tag_len;
   logic [3:0]                             total_len;
   logic [CMP_WIDTH-1:0]                   mask_ext, limit_ext, sum_ext;
   logic                                   overflow;

   assign kind   = req_tuser;
   assign fnum   = req_tdata[pbfe_pkg::FIELD_NUM_WIDTH-1:0];
   assign val    = req_tdata[pbfe_pkg::FIELD_NUM_WIDTH +: pbfe_pkg::VALUE_WIDTH];
   assign zigzag = {val[pbfe_pkg::VALUE_WIDTH-2:0], 1'b0}
                   ^ {pbfe_pkg::VALUE_WIDTH{val[pbfe_pkg::VALUE_WIDTH-1]}};

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      is_field    = 1'b1;
      is_raw      = 1'b0;
      wire_type   = pbfe_pkg::WIRE_VARINT;
      body        = val;
      body_varint = 1'b1;
      fixed_len   = 4'd1;
      case (kind)
         pbfe_pkg::KIND_UVARINT: begin
            wire_type = pbfe_pkg::WIRE_VARINT;
         end
         pbfe_pkg::KIND_ZIGZAG: begin
            wire_type = pbfe_pkg::WIRE_VARINT;
            body      = zigzag;
         end
         pbfe_pkg::KIND_FIXED32: begin
            wire_type   = pbfe_pkg::WIRE_I32;
            body_varint = 1'b0;
            fixed_len   = 4'd4;
         end
         pbfe_pkg::KIND_FIXED64: begin
            wire_type   = pbfe_pkg::WIRE_I64;
            body_varint = 1'b0;
            fixed_len   = 4'd8;
         end
         pbfe_pkg::KIND_LENGTH: begin
            wire_type = pbfe_pkg::WIRE_LEN;
         end
         pbfe_pkg::KIND_RAW: begin
            is_raw      = 1'b1;
            body_varint = 1'b0;
            fixed_len   = 4'd1;
         end
         default: begin
            is_field = 1'b0;
         end
      endcase
   end

   assign tag       = {fnum, wire_type};
   assign tag_len   = is_raw ? 3'd0 : 3'(pbfe_pkg::varint_len(pbfe_pkg::VALUE_WIDTH'(tag)));
   assign body_len  = body_varint ? pbfe_pkg::varint_len(body) : fixed_len;
   assign total_len = 4'(tag_len) + body_len;

   assign mask_ext  = CMP_WIDTH'({COUNT_BITS{1'b1}});
   assign limit_ext = (CMP_WIDTH'(limit_ff) < mask_ext) ? CMP_WIDTH'(limit_ff) : mask_ext;
   assign sum_ext   = CMP_WIDTH'(count_ff) + CMP_WIDTH'(total_len);
   assign overflow  = sticky_ff || (sum_ext > limit_ext);

   always_comb begin
      count_in  = count_ff;
      sticky_in = sticky_ff;
      if (accept) begin
         if (kind == pbfe_pkg::KIND_RESTART) begin
            count_in  = '0;
            sticky_in = 1'b0;
         end else if (is_field) begin
            if (overflow) begin
               sticky_in = 1'b1;
            end else begin
               count_in = sum_ext[COUNT_BITS-1:0];
            end
         end
      end
   end

   assign q_push = accept && is_field;

   always_comb begin
      if (overflow) begin
         q_desc.err         = 1'b1;
         q_desc.tag         = '0;
         q_desc.tag_len     = 3'd0;
         q_desc.body        = '0;
         q_desc.body_len    = 4'd1;
         q_desc.body_varint = 1'b0;
      end else begin
         q_desc.err         = 1'b0;
         q_desc.tag         = tag;
         q_desc.tag_len     = tag_len;
         q_desc.body        = body;
         q_desc.body_len    = body_len;
         q_desc.body_varint = body_varint;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= pbfe_pkg::LIMIT_RESET;
         count_ff  <= '0;
         sticky_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         count_ff  <= count_in;
         sticky_ff <= sticky_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pbfe_queue.sv
// Short work queue that decouples the front end from the byte emitter.
`default_nettype none

module pbfe_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  pbfe_pkg::desc_type  push_desc,
   output logic                full,
   input  wire                 pop,
   output logic                pop_valid,
   output pbfe_pkg::desc_type  pop_desc
);

   pbfe_pkg::desc_type                        entry_ff [pbfe_pkg::QUEUE_DEPTH];
   logic [pbfe_pkg::QUEUE_PTR_WIDTH-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [pbfe_pkg::QUEUE_COUNT_WIDTH-1:0]    count_ff;

   assign full      = (count_ff == pbfe_pkg::QUEUE_COUNT_WIDTH'(pbfe_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_desc  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/pbfe_back.sv
// Back end: queued work becomes registered wire bytes, one item per cycle unless stalled.
`default_nettype none
`include "protobuf_field_encoder_unit_assert.svh"

module pbfe_back (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                q_valid,
   input  pbfe_pkg::desc_type                 q_desc,
   output logic                               q_pop,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [pbfe_pkg::BYTE_WIDTH-1:0]    rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser
);

   logic                                 active_ff, active_in;
   logic                                 err_ff, err_in;
   logic [pbfe_pkg::TAG_WIDTH-1:0]       tag_ff, tag_in;
   logic [2:0]                           tag_left_ff, tag_left_in;
   logic [pbfe_pkg::VALUE_WIDTH-1:0]     body_ff, body_in;
   logic [3:0]                           body_left_ff, body_left_in;
   logic                                 varint_ff, varint_in;

   logic                                 out_valid_ff, out_valid_in;
   logic [pbfe_pkg::BYTE_WIDTH-1:0]      out_byte_ff, out_byte_in;
   logic                                 out_last_ff, out_last_in;
   logic                                 out_err_ff, out_err_in;

   logic                                 out_free;
   logic                                 step;
   logic                                 emit_last;
   logic                                 load;
   logic [pbfe_pkg::BYTE_WIDTH-1:0]      emit_byte;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign step      = active_ff && out_free;
   assign emit_last = (tag_left_ff == 3'd0) && (body_left_ff == 4'd1);
   assign load      = q_valid && (!active_ff || (step && emit_last));
   assign q_pop     = load;

   always_comb begin
      if (tag_left_ff != 3'd0) begin
         emit_byte = {(tag_left_ff > 3'd1), tag_ff[6:0]};
      end else if (varint_ff) begin
         emit_byte = {(body_left_ff > 4'd1), body_ff[6:0]};
      end else begin
         emit_byte = body_ff[pbfe_pkg::BYTE_WIDTH-1:0];
      end
   end

   always_comb begin
      active_in    = active_ff;
      err_in       = err_ff;
      tag_in       = tag_ff;
      tag_left_in  = tag_left_ff;
      body_in      = body_ff;
      body_left_in = body_left_ff;
      varint_in    = varint_ff;
      if (load) begin
         active_in    = 1'b1;
         err_in       = q_desc.err;
         tag_in       = q_desc.tag;
         tag_left_in  = q_desc.tag_len;
         body_in      = q_desc.body;
         body_left_in = q_desc.body_len;
         varint_in    = q_desc.body_varint;
      end else if (step && emit_last) begin
         active_in = 1'b0;
      end else if (step) begin
         if (tag_left_ff != 3'd0) begin
            tag_in      = tag_ff >> 7;
            tag_left_in = tag_left_ff - 3'd1;
         end else begin
            body_in      = varint_ff ? (body_ff >> 7) : (body_ff >> 8);
            body_left_in = body_left_ff - 4'd1;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = emit_last;
         out_err_in   = err_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      tag_ff       <= tag_in;
      tag_left_ff  <= tag_left_in;
      body_ff      <= body_in;
      body_left_ff <= body_left_in;
      varint_ff    <= varint_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_err_ff   <= out_err_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

   `PBFE_ASSERT_NOW(a_err_single, out_valid_ff && out_err_ff,
                    out_last_ff && (out_byte_ff == '0), "error item is not a lone zero item")
   `PBFE_ASSERT_NOW(a_body_left, active_ff, body_left_ff != 4'd0,
                    "active work has no body bytes left")
   `PBFE_ASSERT_NOW(a_err_no_tag, active_ff && err_ff, tag_left_ff == 3'd0,
                    "rejected work carries tag bytes")
   `PBFE_ASSERT_NEXT(a_stay_active, step && !emit_last, active_ff,
                     "work dropped before its last byte")

endmodule

`default_nettype wire

// File: rtl/protobuf_field_encoder_unit.sv
// The first byte of an item passes through the queue, the emitter's work registers
// and the output register. Throughput: one output item per cycle unless rsp_tready
// stalls; a field of n bytes (1 to 15) holds the byte emitter until all n are out,
// while the front end accepts one item per cycle into a four-entry queue unless it
// is full. Restart and unused kinds emit nothing. Reset: synchronous; clears the
// byte count, sticky error and queue, and sets the buffer limit to 65535.
`default_nettype none

module protobuf_field_encoder_unit #(
   parameter int COUNT_BITS = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // Fields from bit 0: field_id[28:0], field_value[92:29], zero pad.
   input  wire  [pbfe_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // Fields from bit 0: req_type[2:0].
   input  wire  [pbfe_pkg::KIND_WIDTH-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // Fields from bit 0: out_byte[7:0].
   output logic [pbfe_pkg::BYTE_WIDTH-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   // Fields from bit 0: overflow_error.
   output logic                                 rsp_tuser,
   input  wire                                  csr_wr_en,
   input  wire  [pbfe_pkg::LIMIT_WIDTH-1:0]     csr_wr_data
);

   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_valid;
   pbfe_pkg::desc_type  push_desc;
   pbfe_pkg::desc_type  pop_desc;

   pbfe_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_push      (q_push),
      .q_desc      (push_desc),
      .q_full      (q_full)
   );

   pbfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_desc  (pop_desc)
   );

   pbfe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_desc     (pop_desc),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
